// ===== rtl/assert_macros.svh =====
// Assertion macros for the LED ring animation engine RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/lra_pkg.sv =====
// Package for the LED ring animation engine: constants, tables, types.
// No dependencies.
package lra_pkg;
    localparam int LED_COUNT_D      = 16;
    localparam int PER_COLOR_D      = 5;
    localparam int PATTERN_LENGTH_D = 10;
    localparam logic [6:0] MAX_LEVEL = 7'd127;

    localparam logic [2:0] MODE_MANUAL = 3'd0;
    localparam logic [2:0] MODE_ON     = 3'd1;
    localparam logic [2:0] MODE_BLINK  = 3'd2;
    localparam logic [2:0] MODE_PULSE  = 3'd3;
    localparam logic [2:0] MODE_CIRCLE = 3'd4;
    localparam logic [2:0] MODE_COUNT  = 3'd5;
    localparam logic [2:0] MODE_DARK   = 3'd7;

    localparam logic [2:0] REG_COLOR  = 3'd0;
    localparam logic [2:0] REG_MODE   = 3'd1;
    localparam logic [2:0] REG_BRIGHT = 3'd2;
    localparam logic [2:0] REG_RATE   = 3'd3;
    localparam logic [2:0] REG_PERIOD = 3'd4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    function automatic logic [4:0] circle_tab(input logic [3:0] i);
        unique case (i)
            4'd0: circle_tab = 5'd8;   4'd1: circle_tab = 5'd16;
            4'd2: circle_tab = 5'd12;  4'd3: circle_tab = 5'd7;
            4'd4: circle_tab = 5'd5;   4'd5: circle_tab = 5'd3;
            4'd6: circle_tab = 5'd1;
            default: circle_tab = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] pulse_tab(input logic [3:0] i);
        unique case (i)
            4'd0: pulse_tab = 5'd1;   4'd1: pulse_tab = 5'd3;
            4'd2: pulse_tab = 5'd8;   4'd3: pulse_tab = 5'd12;
            4'd4: pulse_tab = 5'd16;  4'd5: pulse_tab = 5'd12;
            4'd6: pulse_tab = 5'd8;   4'd7: pulse_tab = 5'd3;
            4'd8: pulse_tab = 5'd1;
            default: pulse_tab = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] blink_tab(input logic [3:0] i);
        blink_tab = (i >= 4'd2 && i <= 4'd6) ? 5'd16 : 5'd0;
    endfunction

    function automatic logic [3:0] shift_ord(input logic [3:0] i);
        unique case (i)
            4'd0: shift_ord = 4'd15;
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5: shift_ord = 4'd5 - i;
            4'd6, 4'd7, 4'd8, 4'd9, 4'd10: shift_ord = 4'd15 - i;
            default: shift_ord = 4'(5'd25 - {1'b0, i});
        endcase
    endfunction

    function automatic logic [3:0] wrap10(input logic [3:0] p);
        wrap10 = (p >= 4'd9) ? 4'd0 : p + 4'd1;
    endfunction

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [11:0] dividend; // magnitude
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [11:0] quotient;
    } div_rsp_t;
endpackage

// ===== rtl/lra_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on lra_pkg.
module lra_divider import lra_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [11:0] q_reg;
    logic [7:0]  r_reg;
    logic [7:0]  d_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [8:0]  trial;
    logic        ge;

    assign trial = {r_reg, q_reg[11]};
    assign ge    = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                q_reg    <= req.dividend;
                d_reg    <= req.divisor;
                r_reg    <= '0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                r_reg   <= 8'(ge ? trial - {1'b0, d_reg} : trial);
                q_reg   <= {q_reg[10:0], ge};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd11) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;
endmodule

// ===== rtl/led_ring_animation_engine_core.sv =====
// Top level of the LED ring animation engine: sequencer, dimmer store, frame output.
// Depends on lra_pkg, lra_divider and assert_macros.svh.
//
//  channel | ports                                   | direction
//  s_      | s_valid s_ready s_command s_led_index ..| in, one command
//  m_      | m_valid m_ready m_dimmer_byte m_slot ...| out, frame bytes
//  cfg     | cfg_we cfg_index cfg_data               | in, register write
//
// A set transaction passes the accept and write states. A tick passes the
// accept state, the prep state, in pulse mode with nonzero rate the load state
// and the serial divider, then compares and updates the dimmer store one entry
// a cycle through the shared scaler, then sends 16 output transactions when a
// dimmer changed (one per cycle when m_ready stays high).
// Reset is synchronous; output stalls hold the frame walk in place.
`include "assert_macros.svh"
module led_ring_animation_engine_core import lra_pkg::*; #(
    parameter int LED_COUNT      = LED_COUNT_D,
    parameter int PER_COLOR      = PER_COLOR_D,
    parameter int PATTERN_LENGTH = PATTERN_LENGTH_D
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [4:0] s_led_index,
    input  logic [7:0] s_level,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_dimmer_byte,
    output logic [3:0] m_slot,
    output logic       m_last_byte,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_LOAD = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_WALK = 7'b0010000,
        ST_SEND = 7'b0100000,
        ST_SET  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0] color_reg;
    logic [2:0] mode_reg;
    logic [7:0] bright_reg, rate_reg, period_reg;

    logic [6:0] dim_reg  [LED_COUNT];
    logic [7:0] sent_reg [LED_COUNT];
    logic [7:0] tick_reg;
    logic [3:0] step_reg;
    logic [3:0] phase_reg [PER_COLOR];
    logic [4:0] clev_reg  [PER_COLOR];

    logic [4:0] idx_reg;
    logic [7:0] lvl_reg;
    logic [3:0] cnt_reg;
    logic       changed_reg;
    logic [4:0] val_reg;      // pattern value for blink/pulse/count
    logic       pneg_reg;
    logic [4:0] pv0_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    lra_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // step counter
    logic [7:0] thr;
    logic [8:0] tinc;
    logic       stepped;
    logic       uses_tick;
    assign thr       = (mode_reg == MODE_COUNT) ? period_reg : {1'b0, rate_reg[7:1]};
    assign tinc      = {1'b0, tick_reg} + 9'd1;
    assign stepped   = tinc > {1'b0, thr};
    assign uses_tick = (mode_reg == MODE_BLINK) || (mode_reg == MODE_PULSE) ||
                       (mode_reg == MODE_CIRCLE) || (mode_reg == MODE_COUNT);

    logic [3:0] ps_now, nx_now;
    assign ps_now = (step_reg < 4'(PATTERN_LENGTH)) ? step_reg : 4'd0;
    assign nx_now = wrap10(ps_now);

    // pattern step as it stands after this tick's counter update
    logic [3:0] ps_upd, nx_upd;
    logic [4:0] pv_cur, pv_nxt;
    assign ps_upd = (uses_tick && stepped && mode_reg != MODE_CIRCLE) ? wrap10(ps_now) : ps_now;
    assign nx_upd = wrap10(ps_upd);
    assign pv_cur = pulse_tab(ps_upd);
    assign pv_nxt = pulse_tab(nx_upd);

    // walk: target level of dimmer cnt_reg through the shared scaler
    logic [1:0] grp;
    logic [2:0] pos;
    logic       in_color;
    logic [4:0] wval;
    logic [12:0] prod;
    logic [6:0] target;
    logic [8:0] scaled;
    logic [1:0] first_c;
    assign grp = (cnt_reg < 4'd5) ? 2'd0 : (cnt_reg < 4'd10) ? 2'd1 :
                 (cnt_reg < 4'd15) ? 2'd2 : 2'd3;
    assign pos = 3'(cnt_reg - {grp, 2'b00} - {2'b00, grp});
    assign first_c = (color_reg == 2'd3) ? 2'd0 : color_reg;
    assign in_color = (grp != 2'd3) && ((color_reg == 2'd3) || (color_reg == grp));
    assign wval = (mode_reg == MODE_CIRCLE) ? clev_reg[pos] : val_reg;
    assign prod = {8'd0, wval} * {5'd0, bright_reg};
    assign scaled = prod[12:4];

    always_comb begin
        target = 7'd0;
        unique case (mode_reg)
            MODE_MANUAL: target = dim_reg[cnt_reg];
            MODE_ON: if (in_color) target = (bright_reg > 8'd127) ? MAX_LEVEL : bright_reg[6:0];
            MODE_BLINK, MODE_PULSE, MODE_CIRCLE:
                if (in_color) target = (scaled > 9'd127) ? MAX_LEVEL : scaled[6:0];
            MODE_COUNT:
                if (grp == first_c && grp != 2'd3 &&
                    {5'd0, pos} < ((rate_reg > 8'd5) ? 8'd5 : rate_reg))
                    target = (scaled > 9'd127) ? MAX_LEVEL : scaled[6:0];
            default: target = 7'd0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        dreq = '0;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = (s_command == CMD_SET) ? ST_SET : ST_PREP;
            ST_SET:  state_next = ST_IDLE;
            ST_PREP: begin
                if (mode_reg == MODE_PULSE && rate_reg != 8'd0)
                    state_next = ST_LOAD;
                else
                    state_next = ST_WALK;
            end
            ST_LOAD: begin
                state_next = ST_DIV;
                dreq.start = 1'b1;
            end
            ST_DIV:  if (drsp.done) state_next = ST_WALK;
            ST_WALK: if (cnt_reg == 4'(LED_COUNT - 1))
                state_next = (changed_reg || (sent_reg[cnt_reg] != {1'b0, target})) ?
                             ST_SEND : ST_IDLE;
            ST_SEND: if (m_ready && cnt_reg == 4'(LED_COUNT - 1)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        // pulse numerator magnitude |v1-v0|*tick, tick and step already updated
        dreq.dividend = {7'd0, (pneg_reg ? pv0_reg - pulse_tab(nx_now)
                                         : pulse_tab(nx_now) - pv0_reg)} * {4'd0, tick_reg};
        dreq.divisor  = rate_reg;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_SEND);
    assign m_dimmer_byte = dim_reg[shift_ord(cnt_reg)];
    assign m_slot        = cnt_reg;
    assign m_last_byte   = (cnt_reg == 4'(LED_COUNT - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            color_reg  <= 2'd0;
            mode_reg   <= MODE_CIRCLE;
            bright_reg <= 8'd127;
            rate_reg   <= 8'd10;
            period_reg <= 8'd10;
            tick_reg   <= '0;
            step_reg   <= '0;
            cnt_reg    <= '0;
            changed_reg <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++) begin
                dim_reg[i]  <= '0;
                sent_reg[i] <= (i == 0) ? 8'hFF : 8'h00;
            end
            for (int i = 0; i < PER_COLOR; i++) begin
                phase_reg[i] <= 4'(2 * i);
                clev_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_COLOR:  color_reg  <= cfg_data[1:0];
                    REG_MODE:   mode_reg   <= cfg_data[2:0];
                    REG_BRIGHT: bright_reg <= cfg_data;
                    REG_RATE:   rate_reg   <= cfg_data;
                    REG_PERIOD: period_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg <= s_led_index;
                    lvl_reg <= s_level;
                    cnt_reg <= '0;
                    changed_reg <= 1'b0;
                end
                ST_SET: if (!idx_reg[4])
                    dim_reg[idx_reg[3:0]] <= (lvl_reg > 8'd127) ? MAX_LEVEL : lvl_reg[6:0];
                ST_PREP: begin
                    if (uses_tick) begin
                        tick_reg <= stepped ? 8'd0 : tinc[7:0];
                        if (stepped && mode_reg != MODE_CIRCLE)
                            step_reg <= ps_upd;
                        if (stepped && mode_reg == MODE_CIRCLE)
                            for (int i = 0; i < PER_COLOR; i++) begin
                                phase_reg[i] <= wrap10(phase_reg[i]);
                                clev_reg[i]  <= circle_tab(wrap10(phase_reg[i]));
                            end
                    end
                    pv0_reg  <= pv_cur;
                    pneg_reg <= pv_nxt < pv_cur;
                    unique case (mode_reg)
                        MODE_BLINK: val_reg <= blink_tab(ps_upd);
                        MODE_COUNT: val_reg <= 5'd8 + {1'b0, pv_cur[4:1]};
                        default:    val_reg <= pv_cur;
                    endcase
                end
                ST_DIV: if (drsp.done)
                    val_reg <= pneg_reg ? pv0_reg - drsp.quotient[4:0]
                                        : pv0_reg + drsp.quotient[4:0];
                ST_WALK: begin
                    if (sent_reg[cnt_reg] != {1'b0, target}) changed_reg <= 1'b1;
                    sent_reg[cnt_reg] <= {1'b0, target};
                    dim_reg[cnt_reg]  <= target;
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_SEND: if (m_ready) cnt_reg <= cnt_reg + 4'd1;
                default: ;
            endcase
        end
    end

    `ASSERT_CLK(a_excl, aclk, aresetn, !(s_ready && m_valid), "ready and valid together")
    `ASSERT_CLK(a_last, aclk, aresetn, (m_valid && m_ready && m_last_byte) |=> s_ready, "no idle")
    `ASSERT_CLK(a_div, aclk, aresetn, drsp.done |-> (state_reg == ST_DIV), "stray divider result")
endmodule

// ===== tb/sv/led_frame_checker.sv =====
// Frame checker for the LED ring animation engine: watches the command, output
// and config channels, mirrors the dimmer and pattern state, compares every frame byte.
// Depends on lra_pkg (command, mode and register codes).
module led_frame_checker import lra_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_command,
    input  logic [4:0]  s_led_index,
    input  logic [7:0]  s_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [6:0]  m_dimmer_byte,
    input  logic [3:0]  m_slot,
    input  logic        m_last_byte,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] level;
        logic [3:0] slot;
        logic       last;
    } frame_byte_t;

    localparam byte unsigned CIRCLE_LUT [10] = '{8, 16, 12, 7, 5, 3, 1, 0, 0, 0};
    localparam byte unsigned PULSE_LUT  [10] = '{1, 3, 8, 12, 16, 12, 8, 3, 1, 0};
    localparam byte unsigned BLINK_LUT  [10] = '{0, 0, 16, 16, 16, 16, 16, 0, 0, 0};
    localparam byte unsigned WIRE_ORDER [16] =
        '{15, 4, 3, 2, 1, 0, 9, 8, 7, 6, 5, 14, 13, 12, 11, 10};

    frame_byte_t expected_bytes[$];
    logic [1:0]  color_sel;
    logic [2:0]  mode;
    logic [7:0]  bright, rate_q, period;
    logic [6:0]  dim [16];
    logic [7:0]  sent [16];
    logic [7:0]  tick_cnt;
    logic [3:0]  step_q;
    logic [3:0]  cphase [5];
    logic [4:0]  clevel [5];

    assign bytes_pending = expected_bytes.size();

    function automatic logic [6:0] clamp_level(int unsigned v);
        return (v > 127) ? 7'd127 : v[6:0];
    endfunction

    function automatic int unsigned scale_by_brightness(int unsigned v);
        return (v * bright) >> 4;
    endfunction

    function automatic bit bump_tick(int unsigned threshold);
        int unsigned n;
        n = tick_cnt + 1;
        if (n > threshold) begin
            tick_cnt = 0;
            return 1;
        end
        tick_cnt = n[7:0];
        return 0;
    endfunction

    function automatic void bump_step();
        step_q = (step_q >= 9) ? 4'd0 : step_q + 4'd1;
    endfunction

    // Runs one animation tick and queues a frame if any dimmer changed.
    function automatic void run_tick();
        int unsigned first, final_c, ps, nx, n, v;
        int signed v0, v1, sv;
        bit changed;
        changed = 0;
        if (color_sel == 2'd3) begin
            first = 0; final_c = 2;
        end else begin
            first = color_sel; final_c = color_sel;
        end
        if (mode != MODE_MANUAL) begin
            foreach (dim[i]) dim[i] = '0;
            case (mode)
                MODE_ON: begin
                    for (int c = first; c <= final_c; c++)
                        for (int i = 0; i < 5; i++) dim[c*5+i] = clamp_level(bright);
                end
                MODE_BLINK, MODE_PULSE: begin
                    if (bump_tick(rate_q >> 1)) bump_step();
                    ps = (step_q < 10) ? step_q : 0;
                    nx = (ps + 1 >= 10) ? 0 : ps + 1;
                    if (mode == MODE_BLINK) begin
                        v = scale_by_brightness(BLINK_LUT[ps]);
                    end else begin
                        v0 = PULSE_LUT[ps];
                        v1 = PULSE_LUT[nx];
                        sv = v0;
                        // signed slope, division truncates toward zero
                        if (rate_q != 0) sv = (v1 - v0) * int'(tick_cnt) / int'(rate_q) + v0;
                        if (sv < 0) sv = 0;
                        v = scale_by_brightness(sv);
                    end
                    for (int c = first; c <= final_c; c++)
                        for (int i = 0; i < 5; i++) dim[c*5+i] = clamp_level(v);
                end
                MODE_CIRCLE: begin
                    if (bump_tick(rate_q >> 1)) begin
                        for (int i = 0; i < 5; i++) begin
                            cphase[i] = (cphase[i] >= 9) ? 4'd0 : cphase[i] + 4'd1;
                            clevel[i] = CIRCLE_LUT[cphase[i]];
                        end
                    end
                    for (int c = first; c <= final_c; c++)
                        for (int i = 0; i < 5; i++)
                            dim[c*5+i] = clamp_level(scale_by_brightness(clevel[i]));
                end
                MODE_COUNT: begin
                    n = (rate_q > 5) ? 5 : rate_q;
                    if (bump_tick(period)) bump_step();
                    ps = (step_q < 10) ? step_q : 0;
                    v = scale_by_brightness(8 + (PULSE_LUT[ps] >> 1));
                    for (int i = 0; i < n; i++) dim[first*5+i] = clamp_level(v);
                end
                default: ;  // dark modes
            endcase
        end
        for (int i = 0; i < 16; i++) begin
            if (sent[i] != {1'b0, dim[i]}) begin
                sent[i] = {1'b0, dim[i]};
                changed = 1;
            end
        end
        if (changed)
            for (int i = 0; i < 16; i++)
                expected_bytes.push_back('{dim[WIRE_ORDER[i]], 4'(i), i == 15});
    endfunction

    always @(posedge aclk) begin
        frame_byte_t got, want;
        if (!aresetn) begin
            color_sel = 2'd0; mode = MODE_CIRCLE; bright = 8'd127;
            rate_q = 8'd10; period = 8'd10;
            tick_cnt = '0; step_q = '0;
            for (int i = 0; i < 16; i++) begin
                dim[i] = '0;
                sent[i] = (i == 0) ? 8'hFF : 8'h00;
            end
            for (int i = 0; i < 5; i++) begin
                cphase[i] = 4'(2 * i);
                clevel[i] = '0;
            end
            expected_bytes.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_COLOR:  color_sel = cfg_data[1:0];
                    REG_MODE:   mode      = cfg_data[2:0];
                    REG_BRIGHT: bright    = cfg_data;
                    REG_RATE:   rate_q    = cfg_data;
                    REG_PERIOD: period    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_command == CMD_SET) begin
                    if (s_led_index < 16) dim[s_led_index[3:0]] = clamp_level(s_level);
                end else begin
                    run_tick();
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_dimmer_byte, m_slot, m_last_byte};
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for led_ring_animation_engine_core: clock, reset, stimulus
// phases and the verdict. Depends on lra_pkg and led_frame_checker.
module tb_top import lra_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0, s_ready;
    logic       s_command = 1'b0;
    logic [4:0] s_led_index = '0;
    logic [7:0] s_level = '0;
    logic       m_valid, m_ready = 1'b0;
    logic [6:0] m_dimmer_byte;
    logic [3:0] m_slot;
    logic       m_last_byte;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    int         fail_count, bytes_pending;
    int         cycle_count = 0;
    bit         sink_hold = 0;   // long stretches with the sink always ready

    always #4 aclk = ~aclk;

    led_ring_animation_engine_core u_dut (.*);
    led_frame_checker u_chk (.*);

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Output side: random stalls between transactions, none while sink_hold.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = sink_hold ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // One transaction on the command channel, with a random lead-in gap unless no_gap.
    // Valid stays high on return; settle() or a later call with a gap drops it.
    task automatic send_cmd(logic cmd, logic [4:0] idx, logic [7:0] lvl, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_led_index <= idx;
        s_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Wait until the checker has no bytes pending, then let the pipeline drain.
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (bytes_pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
    endtask

    task automatic setup(logic [1:0] col, logic [2:0] md, logic [7:0] br,
                         logic [7:0] rt, logic [7:0] per);
        settle();
        write_reg(REG_COLOR, col);
        write_reg(REG_MODE, md);
        write_reg(REG_BRIGHT, br);
        write_reg(REG_RATE, rt);
        write_reg(REG_PERIOD, per);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [2:0] md;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: first tick under reset config, then set extremes.
        send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);
        send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b1);
        setup(2'd3, MODE_MANUAL, 8'd255, 8'd0, 8'd0);
        send_cmd(CMD_SET, 5'd0, 8'd255, 1'b0);      // clamp
        send_cmd(CMD_SET, 5'd15, 8'd127, 1'b0);
        send_cmd(CMD_SET, 5'd31, 8'd200, 1'b1);     // index out of range
        send_cmd(CMD_SET, 5'd16, 8'd1, 1'b0);
        send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);
        send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);       // unchanged frame
        setup(2'd1, MODE_ON, 8'd255, 8'd0, 8'd255);
        send_cmd(CMD_TICK, 5'd31, 8'd255, 1'b0);
        send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);
        setup(2'd2, MODE_DARK, 8'd0, 8'd255, 8'd0);
        send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);
        setup(2'd3, MODE_PULSE, 8'd255, 8'd0, 8'd0);
        repeat (3) send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);
        setup(2'd0, MODE_COUNT, 8'd100, 8'd255, 8'd0);
        repeat (3) send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);
        setup(2'd2, MODE_BLINK, 8'd40, 8'd1, 8'd255);
        repeat (3) send_cmd(CMD_TICK, 5'd0, 8'd0, 1'b0);

        // Random phases: mostly ticks, some dimmer writes, new config each phase.
        for (int ph = 0; ph < 14; ph++) begin
            md = 3'($urandom_range(0, 7));
            if (ph < 4) md = MODE_PULSE;
            setup(2'($urandom_range(0, 3)), md, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                               : $urandom_range(0, 8)),
                  8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                               : $urandom_range(0, 4)));
            sink_hold = (ph % 5 == 2);
            for (int k = 0; k < 14; k++)
                send_cmd($urandom_range(0, 3) == 0 ? CMD_SET : CMD_TICK,
                         5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 3) == 0);
        end
        sink_hold = 0;

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
